// ===== rtl/core/pdct_pkg.sv =====
package pdct_pkg;

   // Field widths
   localparam int unsigned VoltW = 10;
   localparam int unsigned TickW = 24;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrAddrW = 4;

   // Saturation limit of the ticks-since-peak counter
   localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

   // Register reset values
   localparam logic [VoltW-1:0] LowBatteryReset = VoltW'(600);
   localparam logic [VoltW-1:0] MinChargeReset = VoltW'(700);
   localparam logic [VoltW-1:0] DropMarginReset = VoltW'(5);
   localparam logic [TickW-1:0] PeakTimeoutReset = TickW'(1000000);

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_LOW_BATTERY  = 2'd0,
      REG_MIN_CHARGE   = 2'd1,
      REG_DROP_MARGIN  = 2'd2,
      REG_PEAK_TIMEOUT = 2'd3
   } reg_index_type;

   // Request kinds
   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   // Reason a charge ended
   typedef enum logic [1:0] {
      STOP_NONE    = 2'd0,
      STOP_DROP    = 2'd1,
      STOP_TIMEOUT = 2'd2,
      STOP_REFUSED = 2'd3
   } stop_cause_type;

   // Configuration handed from the register file to the engine
   typedef struct packed {
      logic [VoltW-1:0] low_battery_level;
      logic [VoltW-1:0] min_charge_level;
      logic [VoltW-1:0] drop_margin;
      logic [TickW-1:0] peak_timeout;
   } cfg_type;

endpackage

// ===== rtl/core/pdct_intf.sv =====
interface pdct_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [pdct_pkg::VoltW-1:0]   voltage;

   modport source (output valid, output req_type, output voltage, input ready);
   modport sink   (input valid, input req_type, input voltage, output ready);
endinterface

interface pdct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         charge_on;
   logic                         battery_flat;
   logic [pdct_pkg::VoltW-1:0]   peak_level;
   logic [1:0]                   stop_cause;

   modport source (output valid, output charge_on, output battery_flat,
                   output peak_level, output stop_cause, input ready);
   modport sink   (input valid, input charge_on, input battery_flat,
                   input peak_level, input stop_cause, output ready);
endinterface

// ===== rtl/core/pdct_csr.sv =====
module pdct_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdct_pkg::CsrAddrW-1:0]   paddr,
   input  logic [pdct_pkg::CsrDataW-1:0]   pwdata,
   output logic [pdct_pkg::CsrDataW-1:0]   prdata,
   output logic                            pready,
   output pdct_pkg::cfg_type               cfg
);

   pdct_pkg::cfg_type       cfg_ff;
   pdct_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = pdct_pkg::reg_index_type'(paddr[pdct_pkg::CsrAddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Write the addressed register, restore defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_battery_level <= pdct_pkg::LowBatteryReset;
         cfg_ff.min_charge_level  <= pdct_pkg::MinChargeReset;
         cfg_ff.drop_margin       <= pdct_pkg::DropMarginReset;
         cfg_ff.peak_timeout      <= pdct_pkg::PeakTimeoutReset;
      end else if (wr_en) begin
         unique case (index)
            pdct_pkg::REG_LOW_BATTERY:
               cfg_ff.low_battery_level <= pwdata[pdct_pkg::VoltW-1:0];
            pdct_pkg::REG_MIN_CHARGE:
               cfg_ff.min_charge_level <= pwdata[pdct_pkg::VoltW-1:0];
            pdct_pkg::REG_DROP_MARGIN:
               cfg_ff.drop_margin <= pwdata[pdct_pkg::VoltW-1:0];
            pdct_pkg::REG_PEAK_TIMEOUT:
               cfg_ff.peak_timeout <= pwdata[pdct_pkg::TickW-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         pdct_pkg::REG_LOW_BATTERY:
            prdata = pdct_pkg::CsrDataW'(cfg_ff.low_battery_level);
         pdct_pkg::REG_MIN_CHARGE:
            prdata = pdct_pkg::CsrDataW'(cfg_ff.min_charge_level);
         pdct_pkg::REG_DROP_MARGIN:
            prdata = pdct_pkg::CsrDataW'(cfg_ff.drop_margin);
         pdct_pkg::REG_PEAK_TIMEOUT:
            prdata = pdct_pkg::CsrDataW'(cfg_ff.peak_timeout);
         default:
            prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/pdct_engine.sv =====
module pdct_engine (
   input  logic               clock,
   input  logic               reset,
   input  pdct_pkg::cfg_type  cfg,
   pdct_req_if.sink           req,
   pdct_rsp_if.source         rsp
);

   // Input register
   logic                         s1_valid_ff;
   logic                         s1_start_ff;
   logic [pdct_pkg::VoltW-1:0]   s1_voltage_ff;

   // Charge state
   logic                         charging_ff;
   logic [pdct_pkg::VoltW-1:0]   peak_ff;
   logic [pdct_pkg::TickW-1:0]   ticks_ff;

   // Result register
   logic                         out_valid_ff;
   logic                         out_charge_ff;
   logic                         out_flat_ff;
   logic [pdct_pkg::VoltW-1:0]   out_peak_ff;
   pdct_pkg::stop_cause_type     out_cause_ff;

   // Next values
   logic                         charging_in;
   logic [pdct_pkg::VoltW-1:0]   peak_in;
   logic [pdct_pkg::TickW-1:0]   ticks_in;
   logic                         flat_in;
   pdct_pkg::stop_cause_type     cause_in;

   logic advance;
   logic load;

   // Result register frees when empty or taken
   assign advance   = !out_valid_ff || rsp.ready;
   assign load      = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;

   // Capture an item whenever the input register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_start_ff   <= req.req_type;
         s1_voltage_ff <= req.voltage;
      end
   end

   // Start, peak tracking and termination checks
   always_comb begin
      logic [pdct_pkg::VoltW-1:0] fall;
      charging_in = charging_ff;
      peak_in     = peak_ff;
      ticks_in    = ticks_ff;
      cause_in    = pdct_pkg::STOP_NONE;
      flat_in     = s1_voltage_ff < cfg.low_battery_level;
      fall        = '0;
      if (s1_start_ff == pdct_pkg::REQ_START) begin
         if (flat_in && !charging_ff) begin
            charging_in = 1'b1;
            peak_in     = s1_voltage_ff;
            ticks_in    = '0;
         end else begin
            charging_in = 1'b0;
            cause_in    = pdct_pkg::STOP_REFUSED;
         end
      end else if (charging_ff) begin
         if (s1_voltage_ff > peak_ff) begin
            peak_in  = s1_voltage_ff;
            ticks_in = '0;
         end else if (ticks_ff != pdct_pkg::TickMax) begin
            ticks_in = ticks_ff + 1'b1;
         end
         // peak_in never lies below the sample
         fall = peak_in - s1_voltage_ff;
         if (peak_in > cfg.min_charge_level) begin
            if (fall > cfg.drop_margin) begin
               charging_in = 1'b0;
               cause_in    = pdct_pkg::STOP_DROP;
            end else if (ticks_in > cfg.peak_timeout) begin
               charging_in = 1'b0;
               cause_in    = pdct_pkg::STOP_TIMEOUT;
            end
         end
      end
   end

   // Commit state together with the result
   always_ff @(posedge clock) begin
      if (reset) begin
         charging_ff <= 1'b0;
         peak_ff     <= '0;
         ticks_ff    <= '0;
      end else if (load) begin
         charging_ff <= charging_in;
         peak_ff     <= peak_in;
         ticks_ff    <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_charge_ff <= charging_in;
         out_flat_ff   <= flat_in;
         out_peak_ff   <= peak_in;
         out_cause_ff  <= cause_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.charge_on    = out_charge_ff;
   assign rsp.battery_flat = out_flat_ff;
   assign rsp.peak_level   = out_peak_ff;
   assign rsp.stop_cause   = 2'(out_cause_ff);

   // The pending result always mirrors the committed charge state
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_charge_ff == charging_ff && out_peak_ff == peak_ff))
      else $error("result out of step with charge state");

   // Any stop cause leaves charging off
   assert property (@(posedge clock) disable iff (reset)
      (load && cause_in != pdct_pkg::STOP_NONE) |=> !charging_ff)
      else $error("charging still on after a stop");

   // A charge starts only from a start item and with a cleared counter
   assert property (@(posedge clock) disable iff (reset)
      $rose(charging_ff) |-> ($past(s1_start_ff) && ticks_ff == '0))
      else $error("charge began without a start item");

   // Counter only clears or steps by one
   assert property (@(posedge clock) disable iff (reset)
      !$stable(ticks_ff) |-> (ticks_ff == '0 || ticks_ff == $past(ticks_ff) + 1'b1))
      else $error("tick counter jumped");

   // State moves only when an item is processed
   assert property (@(posedge clock) disable iff (reset)
      !$past(load) |-> ($stable(peak_ff) && $stable(charging_ff)))
      else $error("state changed with no item");

endmodule

// ===== rtl/core/peak_drop_charge_terminator_core.sv =====
// An accepted item passes the input register, then the result register, to reach its result.
// One item per cycle unless stalled; compare and counter update fit between the two registers.
// A stalled result holds the result register; the input register still takes one more item.
// Reset (synchronous, active high) stops charging, clears peak and tick count,
// empties both registers and restores the configuration registers to their defaults.
module peak_drop_charge_terminator_core (
   input  logic                            clock,
   input  logic                            reset,
   pdct_req_if.sink                        req_ch,
   pdct_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdct_pkg::CsrAddrW-1:0]   paddr,
   input  logic [pdct_pkg::CsrDataW-1:0]   pwdata,
   output logic [pdct_pkg::CsrDataW-1:0]   prdata,
   output logic                            pready
);

   pdct_pkg::cfg_type cfg;

   // Configuration registers
   pdct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Charge control datapath
   pdct_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

endmodule
